@@ src/gcuf_pkg.sv @@
// Shared types and constants for the graph component union-find block.
// No dependencies.
package gcuf_pkg;

  localparam int ID_W       = 10;
  localparam int NODE_SLOTS = 1 << ID_W;

  typedef logic [ID_W-1:0] node_t;
  typedef logic [1:0]      op_t;

  localparam op_t OP_ADD_NODE = 2'd0;
  localparam op_t OP_ADD_EDGE = 2'd1;
  localparam op_t OP_QUERY    = 2'd2;

  typedef struct packed {
    op_t   op;
    node_t node_a;
    node_t node_b;
  } cmd_t;

  typedef struct packed {
    node_t root;
    node_t lowest_member;
    logic  known;
  } result_t;

endpackage

@@ src/graph_component_union_find.sv @@
// Graph component union-find: stream front end and output register.
// Add node and unknown ops return to ready with no output; a query gives one output beat
// (zero if absent) after a path-halving find; an edge joins the roots of two present nodes.
// Throughput: one item at a time; a query also waits for a free output register.
// Reset: synchronous, active high; a clearing pass over all 1024 entries of the present
// table follows, with s_axis_tready low meanwhile.
module graph_component_union_find
  import gcuf_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,  // node_a[9:0], node_b[19:10], zero pad
  input  logic [1:0]  s_axis_tuser,  // operation[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,  // root[9:0], lowest_member[19:10], zero pad
  output logic [0:0]  m_axis_tuser   // known[0]
);

  cmd_t    cmd;
  result_t res, out_res;
  logic    idle, res_valid, res_ready, start;

  assign cmd.op     = s_axis_tuser;
  assign cmd.node_a = s_axis_tdata[ID_W-1:0];
  assign cmd.node_b = s_axis_tdata[2*ID_W-1:ID_W];

  assign s_axis_tready = idle;
  assign start         = s_axis_tvalid && idle;
  assign res_ready     = !m_axis_tvalid || m_axis_tready;

  gcuf_engine u_engine (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .cmd       (cmd),
    .idle      (idle),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (res_ready) begin
      m_axis_tvalid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) out_res <= res;
  end

  assign m_axis_tdata = {4'b0, out_res.lowest_member, out_res.root};
  assign m_axis_tuser = out_res.known;

endmodule

@@ src/gcuf_engine.sv @@
// Union-find sequencer with present, parent and minimum tables.
// Depends on gcuf_pkg.
module gcuf_engine
  import gcuf_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  input  cmd_t    cmd,
  output logic    idle,
  output logic    res_valid,
  input  logic    res_ready,
  output result_t res
);

  typedef enum logic [10:0] {
    S_IDLE  = 11'b00000000001,
    S_CLEAR = 11'b00000000010,
    S_RDA   = 11'b00000000100,
    S_RDB   = 11'b00000001000,
    S_EDGB  = 11'b00000010000,
    S_FCK1  = 11'b00000100000,
    S_FCK2  = 11'b00001000000,
    S_MRDB  = 11'b00010000000,
    S_MCMP  = 11'b00100000000,
    S_QMIN  = 11'b01000000000,
    S_RESP  = 11'b10000000000
  } state_t;

  state_t  state, state_next;
  cmd_t    cur;
  node_t   x, ra, rb, mina, clr_cnt;
  logic    pa, which;

  logic    pres_mem [NODE_SLOTS];
  node_t   par_mem  [NODE_SLOTS];
  node_t   min_mem  [NODE_SLOTS];

  logic    pres_rd, pres_we, pres_wd;
  node_t   pres_ra, pres_wa;
  node_t   par_rd, par_ra, par_wa, par_wd;
  logic    par_we;
  node_t   min_rd, min_ra, min_wa, min_wd;
  logic    min_we;

  always_ff @(posedge clk) begin
    if (pres_we) pres_mem[pres_wa] <= pres_wd;
    pres_rd <= pres_mem[pres_ra];
  end

  always_ff @(posedge clk) begin
    if (par_we) par_mem[par_wa] <= par_wd;
    par_rd <= par_mem[par_ra];
  end

  always_ff @(posedge clk) begin
    if (min_we) min_mem[min_wa] <= min_wd;
    min_rd <= min_mem[min_ra];
  end

  assign idle      = (state == S_IDLE);
  assign res_valid = (state == S_RESP);

  always_comb begin
    state_next = state;
    pres_ra = cur.node_a;
    pres_we = 1'b0;
    pres_wa = cur.node_a;
    pres_wd = 1'b1;
    par_ra  = x;
    par_we  = 1'b0;
    par_wa  = x;
    par_wd  = par_rd;
    min_ra  = x;
    min_we  = 1'b0;
    min_wa  = rb;
    min_wd  = mina;
    case (state)
      S_IDLE: begin
        if (start) state_next = S_RDA;
      end
      S_CLEAR: begin
        pres_we = 1'b1;
        pres_wa = clr_cnt;
        pres_wd = 1'b0;
        if (clr_cnt == node_t'(NODE_SLOTS - 1)) state_next = S_IDLE;
      end
      S_RDA: begin
        state_next = S_RDB;
      end
      S_RDB: begin
        pres_ra = cur.node_b;
        par_ra  = cur.node_a;
        case (cur.op)
          OP_ADD_NODE: begin
            if (!pres_rd) begin
              pres_we = 1'b1;
              par_we  = 1'b1;
              par_wa  = cur.node_a;
              par_wd  = cur.node_a;
              min_we  = 1'b1;
              min_wa  = cur.node_a;
              min_wd  = cur.node_a;
            end
            state_next = S_IDLE;
          end
          OP_ADD_EDGE: state_next = S_EDGB;
          OP_QUERY:    state_next = pres_rd ? S_FCK1 : S_RESP;
          default:     state_next = S_IDLE;
        endcase
      end
      S_EDGB: begin
        par_ra = cur.node_a;
        state_next = (pa && pres_rd) ? S_FCK1 : S_IDLE;
      end
      S_FCK1: begin
        if (par_rd != x) begin
          par_ra = par_rd;
          state_next = S_FCK2;
        end else if (cur.op == OP_QUERY) begin
          min_ra = x;
          state_next = S_QMIN;
        end else if (!which) begin
          par_ra = cur.node_b;
        end else if (ra != x) begin
          par_we = 1'b1;
          par_wa = ra;
          par_wd = x;
          min_ra = ra;
          state_next = S_MRDB;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_FCK2: begin
        par_we = 1'b1;
        par_wa = x;
        par_wd = par_rd;
        par_ra = par_rd;
        state_next = S_FCK1;
      end
      S_MRDB: begin
        min_ra = rb;
        state_next = S_MCMP;
      end
      S_MCMP: begin
        if (mina < min_rd) min_we = 1'b1;
        state_next = S_IDLE;
      end
      S_QMIN: begin
        state_next = S_RESP;
      end
      S_RESP: begin
        if (res_ready) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLEAR;
      clr_cnt <= '0;
    end else begin
      state <= state_next;
      if (state == S_CLEAR) clr_cnt <= clr_cnt + node_t'(1);
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (start) cur <= cmd;
      end
      S_RDB: begin
        pa    <= pres_rd;
        x     <= cur.node_a;
        which <= 1'b0;
        if (cur.op == OP_QUERY && !pres_rd) res <= '0;
      end
      S_FCK1: begin
        if (par_rd == x && cur.op != OP_QUERY) begin
          if (!which) begin
            ra    <= x;
            x     <= cur.node_b;
            which <= 1'b1;
          end else begin
            rb <= x;
          end
        end
      end
      S_FCK2: begin
        x <= par_rd;
      end
      S_MRDB: begin
        mina <= min_rd;
      end
      S_QMIN: begin
        res.root          <= x;
        res.lowest_member <= min_rd;
        res.known         <= 1'b1;
      end
      default: ;
    endcase
  end

endmodule

@@ src/gcuf_checker.sv @@
// Port-level checks for graph_component_union_find, bound to the top level.
// Depends on gcuf_pkg.
module gcuf_checker
  import gcuf_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [23:0] m_axis_tdata,
  input logic [0:0]  m_axis_tuser
);

  logic in_beat;
  assign in_beat = s_axis_tvalid && s_axis_tready;

  a_clear_after_reset: assert property (@(posedge clk) rst |=> !s_axis_tready)
    else $error("input ready during table clear");

  a_busy_after_beat: assert property (@(posedge clk) disable iff (rst)
    in_beat |=> !s_axis_tready)
    else $error("input ready right after an accepted beat");

  a_unknown_zero: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tuser[0]) |-> (m_axis_tdata == 24'd0))
    else $error("absent-node result carries nonzero fields");

  a_lowest_le_root: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser[0]) |->
      (m_axis_tdata[2*ID_W-1:ID_W] <= m_axis_tdata[ID_W-1:0]))
    else $error("lowest member above root");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=>
      (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
    else $error("stalled output beat changed");

endmodule

bind graph_component_union_find gcuf_checker u_gcuf_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
